// ----- rtl/rmf_pkg.sv -----
// Shared types, constants and compare functions of the RGB 3x3 median filter.
`default_nettype none

package rmf_pkg;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 10;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    // Size limits and register reset values
    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_MAX_HEIGHT   = 1024;
    localparam int RST_IMAGE_WIDTH  = 640;
    localparam int RST_IMAGE_HEIGHT = 480;
    localparam int MIN_SIZE         = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pix;

    // One window column, each channel sorted on its own
    typedef struct packed {
        t_pix lo;
        t_pix mi;
        t_pix hi;
    } t_col;

    // Line buffer entry: pixel two rows up and one row up
    typedef struct packed {
        t_pix upper;
        t_pix middle;
    } t_pair;

    // Max of lows, median of middles, min of highs
    typedef struct packed {
        t_pix a;
        t_pix b;
        t_pix c;
    } t_abc;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } t_meta;

    function automatic logic [PIX_W-1:0] min8(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
        return (x < y) ? x : y;
    endfunction

    function automatic logic [PIX_W-1:0] max8(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
        return (x > y) ? x : y;
    endfunction

    function automatic logic [PIX_W-1:0] med3(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y,
                                              logic [PIX_W-1:0] z);
        return max8(min8(x, y), min8(max8(x, y), z));
    endfunction

    // Sort the three pixels of a new column, per channel
    function automatic t_col sort_col(t_pix p0, t_pix p1, t_pix p2);
        t_col c;
        c.lo.red   = min8(min8(p0.red, p1.red), p2.red);
        c.mi.red   = med3(p0.red, p1.red, p2.red);
        c.hi.red   = max8(max8(p0.red, p1.red), p2.red);
        c.lo.green = min8(min8(p0.green, p1.green), p2.green);
        c.mi.green = med3(p0.green, p1.green, p2.green);
        c.hi.green = max8(max8(p0.green, p1.green), p2.green);
        c.lo.blue  = min8(min8(p0.blue, p1.blue), p2.blue);
        c.mi.blue  = med3(p0.blue, p1.blue, p2.blue);
        c.hi.blue  = max8(max8(p0.blue, p1.blue), p2.blue);
        return c;
    endfunction

    // Reduce three sorted columns to the three median candidates
    function automatic t_abc reduce_cols(t_col c0, t_col c1, t_col c2);
        t_abc r;
        r.a.red   = max8(max8(c0.lo.red, c1.lo.red), c2.lo.red);
        r.b.red   = med3(c0.mi.red, c1.mi.red, c2.mi.red);
        r.c.red   = min8(min8(c0.hi.red, c1.hi.red), c2.hi.red);
        r.a.green = max8(max8(c0.lo.green, c1.lo.green), c2.lo.green);
        r.b.green = med3(c0.mi.green, c1.mi.green, c2.mi.green);
        r.c.green = min8(min8(c0.hi.green, c1.hi.green), c2.hi.green);
        r.a.blue  = max8(max8(c0.lo.blue, c1.lo.blue), c2.lo.blue);
        r.b.blue  = med3(c0.mi.blue, c1.mi.blue, c2.mi.blue);
        r.c.blue  = min8(min8(c0.hi.blue, c1.hi.blue), c2.hi.blue);
        return r;
    endfunction

    // Final median of the candidates
    function automatic t_pix med_abc(t_abc v);
        t_pix p;
        p.red   = med3(v.a.red, v.b.red, v.c.red);
        p.green = med3(v.a.green, v.b.green, v.c.green);
        p.blue  = med3(v.a.blue, v.b.blue, v.c.blue);
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rmf_if.sv -----
// Valid/ready channel interfaces of the RGB 3x3 median filter.
`default_nettype none

interface rmf_pix_if import rmf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_red;
    logic [PIX_W-1:0] pixel_green;
    logic [PIX_W-1:0] pixel_blue;

    modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                    input ready);
    modport sink   (input valid, input pixel_red, input pixel_green, input pixel_blue,
                    output ready);
endinterface

interface rmf_res_if import rmf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   median_red;
    logic [PIX_W-1:0]   median_green;
    logic [PIX_W-1:0]   median_blue;
    logic [COORD_W-1:0] center_column;
    logic [COORD_W-1:0] center_row;
    logic               frame_last;

    modport source (output valid, output median_red, output median_green,
                    output median_blue, output center_column, output center_row,
                    output frame_last, input ready);
    modport sink   (input valid, input median_red, input median_green,
                    input median_blue, input center_column, input center_row,
                    input frame_last, output ready);
endinterface

interface rmf_cfg_if import rmf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/rmf_line_buf.sv -----
// Two-row line buffer: one entry per column holding the pixels one and two rows up.
`default_nettype none

module rmf_line_buf import rmf_pkg::*; #(
    parameter int  DEPTH = DEF_MAX_WIDTH,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_pair              o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_pair         i_wr_data
);

    t_pair r_mem [DEPTH];
    t_pair r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/rmf_col_cell.sv -----
// One window column cell: holds a sorted column and passes it to its left neighbor.
`default_nettype none

module rmf_col_cell import rmf_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_shift,
    input  wire t_col i_col,
    output t_col      o_col
);

    t_col r_col;

    // Take the column from the right neighbor on each pixel
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

`default_nettype wire

// ----- rtl/rmf_median_stage.sv -----
// Median candidate stage: reduces three sorted columns to max-of-lows, median-of-middles
// and min-of-highs per channel.
`default_nettype none

module rmf_median_stage import rmf_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_advance,
    input  wire logic  i_valid,
    input  wire t_col  i_cols [3],
    input  wire t_meta i_meta,
    output logic       o_valid,
    output t_abc       o_abc,
    output t_meta      o_meta
);

    logic  r_valid;
    t_abc  r_abc;
    t_meta r_meta;

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_valid;
        end
    end

    // Capture candidates of a complete window
    always_ff @(posedge i_clk) begin
        if (i_advance && i_valid) begin
            r_abc  <= reduce_cols(i_cols[0], i_cols[1], i_cols[2]);
            r_meta <= i_meta;
        end
    end

    assign o_valid = r_valid;
    assign o_abc   = r_abc;
    assign o_meta  = r_meta;

endmodule

`default_nettype wire

// ----- rtl/rgb_median_filter_3x3.sv -----
// Top level of the streaming RGB 3x3 median filter.
//
// Usage: pixels enter in raster order on i_pix (valid/ready), one pixel per clock at
// full rate unless o_res stalls. For every interior pixel (not in the first or last
// row or column) one result leaves on o_res: the per-channel median of the 3x3
// neighborhood, the center column and row, and frame_last on the last interior result
// of the frame. Border pixels are consumed and give no result. Image size is set
// through i_cfg (index 0: width, index 1: height, clamped to 3..MAX); the port is
// always ready and should be written only while no pixel is in flight.
// Pipeline: stage 1 with the line buffer read, window shift, candidate stage and output
// register lie between the transfer of the pixel that completes a window and its
// result. Throughput: one pixel per cycle unless o_res stalls, set by one line buffer
// read and one write-back per cycle on separate ports and the three-cell window chain.
// A stall on o_res freezes the whole pipeline and drops i_pix.ready in the same cycle;
// no transfer is lost. Reset restores 640x480 and clears the counters and pipeline;
// the line buffer is not cleared, since every entry is written in a row before it is
// read by the following rows.
`default_nettype none

module rgb_median_filter_3x3 import rmf_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rmf_cfg_if.sink   i_cfg,
    rmf_pix_if.sink   i_pix,
    rmf_res_if.source o_res
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int RST_LAST_COL =
        ((RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH) - 1;
    localparam int RST_LAST_ROW =
        ((RST_IMAGE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_IMAGE_HEIGHT) - 1;

    // Clamp a written size and turn it into the last index
    function automatic int clamp_last(logic [CFG_DATA_W-1:0] v, int max_size);
        int n;
        n = int'(v);
        if (n < MIN_SIZE) begin
            n = MIN_SIZE;
        end else if (n > max_size) begin
            n = max_size;
        end
        return n - 1;
    endfunction

    logic [CW-1:0] r_last_col;
    logic [RW-1:0] r_last_row;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic          advance;
    logic          accept;
    logic [CW-1:0] w_ccol;
    logic [RW-1:0] w_crow;
    logic          w_emit;
    logic          w_last;

    logic          r_s1_valid;
    t_pix          r_s1_pix;
    logic [CW-1:0] r_s1_col;
    logic          r_s1_emit;
    t_meta         r_s1_meta;

    t_pair         w_rd;
    t_pair         w_wr;
    logic          shift;
    t_col          w_new_col;
    t_col          w_cols [3];
    logic          r_w_valid;
    t_meta         r_w_meta;

    logic          m_valid;
    t_abc          m_abc;
    t_meta         m_meta;

    logic          r_out_valid;
    t_pix          r_out_pix;
    t_meta         r_out_meta;

    // Pipeline moves whenever the output register is free or being emptied
    assign advance     = !r_out_valid || o_res.ready;
    assign i_pix.ready = advance;
    assign accept      = i_pix.valid && advance;
    assign i_cfg.ready = 1'b1;

    // Size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= CW'(RST_LAST_COL);
            r_last_row <= RW'(RST_LAST_ROW);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_IMAGE_WIDTH:  r_last_col <= CW'(clamp_last(i_cfg.data, MAX_WIDTH));
                CFG_IMAGE_HEIGHT: r_last_row <= RW'(clamp_last(i_cfg.data, MAX_HEIGHT));
                default: ;
            endcase
        end
    end

    // Raster position of the next pixel
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (r_col >= r_last_col) begin
                n_col = '0;
                n_row = (r_row >= r_last_row) ? '0 : RW'(r_row + 1'b1);
            end else begin
                n_col = CW'(r_col + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Result flags and center position of the current pixel
    assign w_ccol = CW'(r_col - 1'b1);
    assign w_crow = RW'(r_row - 1'b1);
    assign w_emit = (r_col >= CW'(2)) && (r_row >= RW'(2));
    assign w_last = (r_col >= r_last_col) && (r_row >= r_last_row);

    // Stage 1: pixel waits for its line buffer read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix.red   <= i_pix.pixel_red;
            r_s1_pix.green <= i_pix.pixel_green;
            r_s1_pix.blue  <= i_pix.pixel_blue;
            r_s1_col       <= r_col;
            r_s1_emit      <= w_emit;
            r_s1_meta.col  <= COORD_W'(w_ccol);
            r_s1_meta.row  <= COORD_W'(w_crow);
            r_s1_meta.last <= w_last;
        end
    end

    // Line buffer: read at transfer, write back shifted rows when stage 1 moves on
    assign shift       = advance && r_s1_valid;
    assign w_wr.upper  = w_rd.middle;
    assign w_wr.middle = r_s1_pix;

    rmf_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (w_rd),
        .i_wr_en   (shift),
        .i_wr_addr (r_s1_col),
        .i_wr_data (w_wr)
    );

    // Window: chain of three column cells, newest column on the right
    assign w_new_col = sort_col(w_rd.upper, w_rd.middle, r_s1_pix);

    for (genvar k = 0; k < 3; k++) begin : g_cell
        if (k == 2) begin : g_right
            rmf_col_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (shift),
                .i_col   (w_new_col),
                .o_col   (w_cols[k])
            );
        end else begin : g_inner
            rmf_col_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (shift),
                .i_col   (w_cols[k+1]),
                .o_col   (w_cols[k])
            );
        end
    end

    // Window holds a complete neighborhood to filter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
        end else if (advance) begin
            r_w_valid <= r_s1_valid && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_w_meta <= r_s1_meta;
        end
    end

    rmf_median_stage u_median_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_valid   (r_w_valid),
        .i_cols    (w_cols),
        .i_meta    (r_w_meta),
        .o_valid   (m_valid),
        .o_abc     (m_abc),
        .o_meta    (m_meta)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && m_valid) begin
            r_out_pix  <= med_abc(m_abc);
            r_out_meta <= m_meta;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.median_red    = r_out_pix.red;
    assign o_res.median_green  = r_out_pix.green;
    assign o_res.median_blue   = r_out_pix.blue;
    assign o_res.center_column = r_out_meta.col;
    assign o_res.center_row    = r_out_meta.row;
    assign o_res.frame_last    = r_out_meta.last;

    // A new read never targets the column whose write-back is still pending
    a_no_rw_hazard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !(r_s1_valid && (r_s1_col == r_col)))
        else $error("line buffer read hits pending write-back column");

    // A frozen pipeline keeps its stage valids
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_s1_valid) && $stable(r_w_valid) && $stable(m_valid))
        else $error("pipeline stage changed during stall");

    // Pixels of the first row never produce a result
    a_first_row_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (r_row == '0)) |=> !r_s1_emit)
        else $error("first-row pixel marked for a result");

    // A transferred pixel reaches stage 1
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("transferred pixel lost before stage 1");

endmodule

`default_nettype wire
